// ----- rtl/mlnf_pkg.sv -----
// Package for the mono legato note filter: action and opcode codes,
// the configuration register map and record, and the glide time function.
// It depends on nothing else and is compiled first.
package mlnf_pkg;

	// Event opcodes; every other code is a plain event.
	localparam logic [1:0] OP_NOTE_ON  = 2'd0;
	localparam logic [1:0] OP_NOTE_OFF = 2'd1;

	// Result actions.
	typedef enum logic [2:0] {
		ACT_DROP     = 3'd0,
		ACT_FORWARD  = 3'd1,
		ACT_NOTE_OFF = 3'd2,
		ACT_LEGATO   = 3'd3,
		ACT_STYLE    = 3'd4
	} act_t;

	// Register indexes on the configuration port (byte address is four times these).
	localparam logic [2:0] REG_LEGATO_ENABLE  = 3'd0;
	localparam logic [2:0] REG_LOWEST_NOTE    = 3'd1;
	localparam logic [2:0] REG_HIGHEST_NOTE   = 3'd2;
	localparam logic [2:0] REG_KEYSWITCH_LOW  = 3'd3;
	localparam logic [2:0] REG_KEYSWITCH_HIGH = 3'd4;
	localparam logic [2:0] REG_LEGATO_GAP     = 3'd5;

	// Register reset values.
	localparam logic        RST_LEGATO_ENABLE  = 1'b1;
	localparam logic [6:0]  RST_LOWEST_NOTE    = 7'd28;
	localparam logic [6:0]  RST_HIGHEST_NOTE   = 7'd67;
	localparam logic [6:0]  RST_KEYSWITCH_LOW  = 7'd24;
	localparam logic [6:0]  RST_KEYSWITCH_HIGH = 7'd27;
	localparam logic [15:0] RST_LEGATO_GAP     = 16'd2646;

	// Glide and pull-off constants.
	localparam logic [8:0] SHORT_GLIDE    = 9'd6;
	localparam logic [8:0] GLIDE_PER_STEP = 9'd25;
	localparam logic [8:0] MAX_GLIDE      = 9'd280;
	localparam logic [8:0] PULL_OFF_GLIDE = 9'd8;
	localparam logic [6:0] PULL_OFF_VEL   = 7'd57;
	localparam logic [6:0] MAX_LEGATO_STEP = 7'd7;

	// Configuration record handed from the register block to the datapath.
	typedef struct packed {
		logic        legato_enable;
		logic [6:0]  lowest_note;
		logic [6:0]  highest_note;
		logic [6:0]  keyswitch_low;
		logic [6:0]  keyswitch_high;
		logic [15:0] legato_gap;
	} cfg_t;

	// Glide time in milliseconds for a pitch step of one to seven semitones.
	function automatic logic [8:0] glide_time(input logic [2:0] step);
		logic [8:0] g;
		if (step <= 3'd2) begin
			g = SHORT_GLIDE;
		end else begin
			g = GLIDE_PER_STEP * {6'd0, step};
		end
		if (g > MAX_GLIDE) begin
			g = MAX_GLIDE;
		end
		return g;
	endfunction

endpackage

// ----- rtl/mlnf_if.sv -----
// Valid/ready channel interfaces for the note filter: the note event
// item going in and the filter result item coming out. No dependencies.
interface mlnf_evt_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [6:0]  note;
	logic [6:0]  velocity;
	logic [3:0]  channel;
	logic [47:0] timestamp;
	logic        voice_active;

	modport source (output valid, opcode, note, velocity, channel, timestamp,
		voice_active, input ready);
	modport sink (input valid, opcode, note, velocity, channel, timestamp,
		voice_active, output ready);
endinterface

interface mlnf_res_if;
	logic       valid;
	logic       ready;
	logic [2:0] action;
	logic [6:0] out_note;
	logic [6:0] out_velocity;
	logic [3:0] out_channel;
	logic [8:0] glide_ms;
	logic [6:0] style_index;

	modport source (output valid, action, out_note, out_velocity, out_channel,
		glide_ms, style_index, input ready);
	modport sink (input valid, action, out_note, out_velocity, out_channel,
		glide_ms, style_index, output ready);
endinterface

// ----- rtl/mono_legato_note_filter_unit.sv -----
// Top level of the mono legato note filter: sequencer, held-note memory
// and result register. Depends on mlnf_pkg, mlnf_if and mlnf_cfg_regs.
//
// The block takes one note event item and returns exactly one result item
// for it. Plain events, drops, style selects and ordinary note-ons go from
// S_DECODE straight to S_DONE, where the output register is loaded once it is
// free. A legato note-on and every playable note-off walk the held-note memory,
// one entry a cycle through its single registered read port, and then pass
// through S_PUSH or S_FINISH to S_DONE. The held notes form a ring in that
// memory, so dropping the oldest note on overflow only moves the head pointer.
// The next item is accepted as soon as a result is loaded, even while that
// result still waits on the output channel. No clearing pass follows reset:
// entries are read only after they have been written.
module mono_legato_note_filter_unit
	import mlnf_pkg::*;
#(
	parameter int HELD_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	mlnf_evt_if.sink    note_evt,
	mlnf_res_if.source  note_res,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int PTR_W = (HELD_DEPTH > 1) ? $clog2(HELD_DEPTH) : 1;
	localparam int CNT_W = $clog2(HELD_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(HELD_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(HELD_DEPTH);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_DECODE = 6'b000010,
		S_WALK   = 6'b000100,
		S_PUSH   = 6'b001000,
		S_FINISH = 6'b010000,
		S_DONE   = 6'b100000
	} state_t;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == LAST_PTR) ? '0 : p + 1'b1;
	endfunction

	cfg_t cfg;

	mlnf_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	state_t state_q;

	// Captured input item.
	logic [1:0]  op_q;
	logic [6:0]  note_q;
	logic [6:0]  vel_q;
	logic [3:0]  ch_q;
	logic [47:0] ts_q;
	logic        active_q;

	// Filter state.
	logic             tracked_vld_q;
	logic [6:0]       tracked_q;
	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic [CNT_W-1:0] count_q;
	logic [47:0]      last_on_q;
	logic             last_on_vld_q;

	// Walk over the held set.
	logic             remove_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W-1:0] wr_ptr_q;
	logic [CNT_W-1:0] iss_q;
	logic [CNT_W-1:0] kept_q;
	logic             rvalid_q;
	logic             found_q;
	logic [6:0]       back_q;

	// Pending result and output register.
	act_t       res_act_q;
	logic [6:0] res_note_q;
	logic [6:0] res_vel_q;
	logic [3:0] res_ch_q;
	logic [8:0] res_glide_q;
	logic [6:0] res_style_q;
	logic       out_vld_q;
	act_t       out_act_q;
	logic [6:0] out_note_q;
	logic [6:0] out_vel_q;
	logic [3:0] out_ch_q;
	logic [8:0] out_glide_q;
	logic [6:0] out_style_q;

	// Held-note memory.
	logic [6:0]       held_mem [HELD_DEPTH];
	logic [6:0]       rdata_q;
	logic             mem_we;
	logic [PTR_W-1:0] mem_waddr;
	logic [6:0]       mem_wdata;

	// Event classification.
	logic        is_on;
	logic        is_off;
	logic        is_ks;
	logic        in_range;
	logic [48:0] ts_diff;
	logic        time_ok;
	logic [6:0]  step;
	logic        legato_go;
	logic        walk_done;
	logic        note_match;
	logic        accept;
	logic        load_out;

	assign accept   = note_evt.valid && note_evt.ready;
	assign load_out = (state_q == S_DONE) && (!out_vld_q || note_res.ready);

	assign is_on    = (op_q == OP_NOTE_ON) && (vel_q != 7'd0);
	assign is_off   = (op_q == OP_NOTE_OFF) || ((op_q == OP_NOTE_ON) && (vel_q == 7'd0));
	assign is_ks    = (note_q >= cfg.keyswitch_low) && (note_q <= cfg.keyswitch_high);
	assign in_range = (note_q >= cfg.lowest_note) && (note_q <= cfg.highest_note);

	// Signed time since the last note-on must exceed the gap.
	assign ts_diff = {1'b0, ts_q} - {1'b0, last_on_q};
	assign time_ok = !last_on_vld_q || ($signed(ts_diff) > $signed({33'd0, cfg.legato_gap}));

	assign step = (note_q > tracked_q) ? (note_q - tracked_q) : (tracked_q - note_q);
	assign legato_go = cfg.legato_enable && tracked_vld_q && time_ok && active_q &&
		(step != 7'd0) && (step <= MAX_LEGATO_STEP);

	assign walk_done  = (iss_q == count_q) && !rvalid_q;
	assign note_match = tracked_vld_q && (tracked_q == note_q);

	// Memory write port.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = head_q;
		mem_wdata = note_q;
		case (state_q)
			S_DECODE: begin
				// An ordinary note-on restarts the held set with this note.
				mem_we = is_on && !is_ks && in_range && !legato_go;
			end
			S_WALK: begin
				if (remove_q && rvalid_q && (rdata_q != note_q)) begin
					mem_we    = 1'b1;
					mem_waddr = wr_ptr_q;
					mem_wdata = rdata_q;
				end
			end
			S_PUSH: begin
				mem_we    = !found_q;
				mem_waddr = tail_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			held_mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= held_mem[rd_ptr_q];
	end

	// Capture of the input item.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= note_evt.opcode;
			note_q   <= note_evt.note;
			vel_q    <= note_evt.velocity;
			ch_q     <= note_evt.channel;
			ts_q     <= note_evt.timestamp;
			active_q <= note_evt.voice_active;
		end
	end

	// Sequencer and filter state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			tracked_vld_q <= 1'b0;
			head_q        <= '0;
			tail_q        <= '0;
			count_q       <= '0;
			last_on_vld_q <= 1'b0;
			last_on_q     <= '0;
			rvalid_q      <= 1'b0;
			iss_q         <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					state_q  <= S_DONE;
					rd_ptr_q <= head_q;
					wr_ptr_q <= head_q;
					iss_q    <= '0;
					kept_q   <= '0;
					rvalid_q <= 1'b0;
					found_q  <= 1'b0;
					if (is_on && !is_ks && in_range) begin
						tracked_vld_q <= 1'b1;
						tracked_q     <= note_q;
						last_on_q     <= ts_q;
						last_on_vld_q <= 1'b1;
						if (legato_go) begin
							remove_q <= 1'b0;
							state_q  <= S_WALK;
						end else begin
							count_q <= CNT_W'(1);
							tail_q  <= ptr_inc(head_q);
						end
					end else if (is_off && !is_ks && in_range) begin
						remove_q <= 1'b1;
						state_q  <= S_WALK;
					end
				end
				S_WALK: begin
					if (iss_q != count_q) begin
						rd_ptr_q <= ptr_inc(rd_ptr_q);
						iss_q    <= iss_q + 1'b1;
						rvalid_q <= 1'b1;
					end else begin
						rvalid_q <= 1'b0;
					end
					if (rvalid_q) begin
						if (!remove_q) begin
							if (rdata_q == note_q) begin
								found_q <= 1'b1;
							end
						end else if (rdata_q != note_q) begin
							wr_ptr_q <= ptr_inc(wr_ptr_q);
							kept_q   <= kept_q + 1'b1;
							back_q   <= rdata_q;
						end
					end
					if (walk_done) begin
						state_q <= remove_q ? S_FINISH : S_PUSH;
					end
				end
				S_PUSH: begin
					// Append at the tail; a full ring drops its oldest entry.
					if (!found_q) begin
						tail_q <= ptr_inc(tail_q);
						if (count_q == FULL_CNT) begin
							head_q <= ptr_inc(head_q);
						end else begin
							count_q <= count_q + 1'b1;
						end
					end
					state_q <= S_DONE;
				end
				S_FINISH: begin
					count_q <= kept_q;
					tail_q  <= wr_ptr_q;
					if (note_match) begin
						if (kept_q != '0) begin
							if (active_q) begin
								tracked_q <= back_q;
							end
						end else begin
							tracked_vld_q <= 1'b0;
						end
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Result selection.
	always_ff @(posedge clk) begin
		case (state_q)
			S_DECODE: begin
				res_act_q   <= ACT_FORWARD;
				res_note_q  <= note_q;
				res_vel_q   <= vel_q;
				res_ch_q    <= ch_q;
				res_glide_q <= '0;
				res_style_q <= '0;
				if (is_on) begin
					if (is_ks) begin
						res_act_q   <= ACT_STYLE;
						res_style_q <= note_q - cfg.keyswitch_low;
					end else if (!in_range) begin
						res_act_q  <= ACT_DROP;
						res_note_q <= '0;
						res_vel_q  <= '0;
						res_ch_q   <= '0;
					end else if (legato_go) begin
						res_act_q   <= ACT_LEGATO;
						res_glide_q <= glide_time(step[2:0]);
					end
				end else if (is_off && (is_ks || !in_range)) begin
					res_act_q  <= ACT_DROP;
					res_note_q <= '0;
					res_vel_q  <= '0;
					res_ch_q   <= '0;
				end
			end
			S_FINISH: begin
				if (note_match) begin
					if (kept_q != '0) begin
						if (active_q) begin
							res_act_q   <= ACT_LEGATO;
							res_note_q  <= back_q;
							res_vel_q   <= PULL_OFF_VEL;
							res_glide_q <= PULL_OFF_GLIDE;
						end
					end else begin
						res_act_q  <= ACT_NOTE_OFF;
						res_note_q <= tracked_q;
					end
				end
			end
			default: ;
		endcase
	end

	// Output register: holds a result until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (load_out) begin
			out_vld_q <= 1'b1;
		end else if (note_res.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_act_q   <= res_act_q;
			out_note_q  <= res_note_q;
			out_vel_q   <= res_vel_q;
			out_ch_q    <= res_ch_q;
			out_glide_q <= res_glide_q;
			out_style_q <= res_style_q;
		end
	end

	assign note_evt.ready        = (state_q == S_IDLE);
	assign note_res.valid        = out_vld_q;
	assign note_res.action       = out_act_q;
	assign note_res.out_note     = out_note_q;
	assign note_res.out_velocity = out_vel_q;
	assign note_res.out_channel  = out_ch_q;
	assign note_res.glide_ms     = out_glide_q;
	assign note_res.style_index  = out_style_q;

endmodule

// ----- rtl/mlnf_cfg_regs.sv -----
// APB-style configuration registers of the note filter.
// Depends on mlnf_pkg for the register map and the configuration record.
module mlnf_cfg_regs
	import mlnf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[4:2];
	assign cfg     = cfg_q;

	// Register writes in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.legato_enable  <= RST_LEGATO_ENABLE;
			cfg_q.lowest_note    <= RST_LOWEST_NOTE;
			cfg_q.highest_note   <= RST_HIGHEST_NOTE;
			cfg_q.keyswitch_low  <= RST_KEYSWITCH_LOW;
			cfg_q.keyswitch_high <= RST_KEYSWITCH_HIGH;
			cfg_q.legato_gap     <= RST_LEGATO_GAP;
		end else if (wr_en) begin
			case (reg_idx)
				REG_LEGATO_ENABLE:  cfg_q.legato_enable  <= pwdata[0];
				REG_LOWEST_NOTE:    cfg_q.lowest_note    <= pwdata[6:0];
				REG_HIGHEST_NOTE:   cfg_q.highest_note   <= pwdata[6:0];
				REG_KEYSWITCH_LOW:  cfg_q.keyswitch_low  <= pwdata[6:0];
				REG_KEYSWITCH_HIGH: cfg_q.keyswitch_high <= pwdata[6:0];
				REG_LEGATO_GAP:     cfg_q.legato_gap     <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Read-back multiplexer.
	always_comb begin
		case (reg_idx)
			REG_LEGATO_ENABLE:  prdata = {31'd0, cfg_q.legato_enable};
			REG_LOWEST_NOTE:    prdata = {25'd0, cfg_q.lowest_note};
			REG_HIGHEST_NOTE:   prdata = {25'd0, cfg_q.highest_note};
			REG_KEYSWITCH_LOW:  prdata = {25'd0, cfg_q.keyswitch_low};
			REG_KEYSWITCH_HIGH: prdata = {25'd0, cfg_q.keyswitch_high};
			REG_LEGATO_GAP:     prdata = {16'd0, cfg_q.legato_gap};
			default:            prdata = 32'd0;
		endcase
	end

endmodule

// ----- verif/mlnf_checker.sv -----
`timescale 1ns / 100ps
// Result checker for the mono legato note filter: watches the event, result
// and register channels, tracks the filter state and compares each result.
// Depends on mlnf_pkg and the channel interfaces in mlnf_if.
module mlnf_checker
	import mlnf_pkg::*;
#(
	parameter int HELD_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	mlnf_evt_if         evt,
	mlnf_res_if         res,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output int unsigned fail_count,
	output int unsigned results_due
);

	typedef struct packed {
		act_t       action;
		logic [6:0] note;
		logic [6:0] velocity;
		logic [3:0] channel;
		logic [8:0] glide;
		logic [6:0] style;
	} note_result_t;

	// Shadow of the register file and of the filter state.
	cfg_t         cfg;
	int           sounding_note;
	logic [6:0]   held [HELD_DEPTH];
	int           held_cnt;
	logic [47:0]  last_on_ts;
	logic         last_on_seen;
	note_result_t results_q[$];

	function automatic bit held_contains(logic [6:0] n);
		int i;
		for (i = 0; i < held_cnt; i++) begin
			if (held[i] == n) begin
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	// A full set gives up its oldest note to make room.
	function automatic void held_add(logic [6:0] n);
		int i;
		if (held_cnt >= HELD_DEPTH) begin
			for (i = 0; i < HELD_DEPTH - 1; i++) begin
				held[i] = held[i + 1];
			end
			held_cnt = HELD_DEPTH - 1;
		end
		held[held_cnt] = n;
		held_cnt++;
	endfunction

	function automatic void held_drop(logic [6:0] n);
		int i, j;
		j = 0;
		for (i = 0; i < held_cnt; i++) begin
			if (held[i] != n) begin
				held[j] = held[i];
				j++;
			end
		end
		held_cnt = j;
	endfunction

	// Works out the result of one event and moves the filter state on.
	function automatic note_result_t filter_note_event(logic [1:0] op, logic [6:0] n,
			logic [6:0] vel, logic [3:0] ch, logic [47:0] ts, logic active);
		note_result_t r;
		bit           note_on, note_off, keyswitch, playable, gap_ok;
		int           step;
		longint       since;
		logic [6:0]   back;
		r = '0;
		r.action = ACT_FORWARD;
		r.note = n;
		r.velocity = vel;
		r.channel = ch;
		note_on = (op == OP_NOTE_ON) && (vel != 7'd0);
		note_off = (op == OP_NOTE_OFF) || ((op == OP_NOTE_ON) && (vel == 7'd0));
		keyswitch = (n >= cfg.keyswitch_low) && (n <= cfg.keyswitch_high);
		playable = (n >= cfg.lowest_note) && (n <= cfg.highest_note);
		if (note_on) begin
			if (keyswitch) begin
				r.action = ACT_STYLE;
				r.style = n - cfg.keyswitch_low;
			end else if (!playable) begin
				r = '0;
			end else begin
				since = longint'(ts) - longint'(last_on_ts);
				gap_ok = !last_on_seen || (since > longint'(cfg.legato_gap));
				step = (int'(n) > sounding_note) ? int'(n) - sounding_note
					: sounding_note - int'(n);
				if (cfg.legato_enable && sounding_note >= 0 && gap_ok && active
						&& step >= 1 && step <= int'(MAX_LEGATO_STEP)) begin
					// Hammer-on or slide to a nearby note.
					r.action = ACT_LEGATO;
					r.glide = (step <= 2) ? SHORT_GLIDE : GLIDE_PER_STEP * 9'(step);
					if (r.glide > MAX_GLIDE) begin
						r.glide = MAX_GLIDE;
					end
					if (!held_contains(n)) begin
						held_add(n);
					end
				end else begin
					held_cnt = 0;
					held_add(n);
				end
				sounding_note = int'(n);
				last_on_ts = ts;
				last_on_seen = 1'b1;
			end
		end else if (note_off) begin
			if (keyswitch || !playable) begin
				r = '0;
			end else begin
				held_drop(n);
				if (int'(n) == sounding_note) begin
					if (held_cnt == 0) begin
						// Last note released: turn off what actually sounds.
						r.action = ACT_NOTE_OFF;
						r.note = 7'(sounding_note);
						sounding_note = -1;
					end else if (active) begin
						// Pull-off to the newest note still held.
						back = held[held_cnt - 1];
						sounding_note = int'(back);
						r.action = ACT_LEGATO;
						r.note = back;
						r.velocity = PULL_OFF_VEL;
						r.glide = PULL_OFF_GLIDE;
					end
				end
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		note_result_t got, want;
		if (!arst_n) begin
			cfg = '{RST_LEGATO_ENABLE, RST_LOWEST_NOTE, RST_HIGHEST_NOTE,
				RST_KEYSWITCH_LOW, RST_KEYSWITCH_HIGH, RST_LEGATO_GAP};
			sounding_note = -1;
			held_cnt = 0;
			last_on_ts = '0;
			last_on_seen = 1'b0;
			results_q.delete();
			fail_count = 0;
			results_due <= 0;
		end else begin
			// Register writes land at the access edge.
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					REG_LEGATO_ENABLE:  cfg.legato_enable = pwdata[0];
					REG_LOWEST_NOTE:    cfg.lowest_note = pwdata[6:0];
					REG_HIGHEST_NOTE:   cfg.highest_note = pwdata[6:0];
					REG_KEYSWITCH_LOW:  cfg.keyswitch_low = pwdata[6:0];
					REG_KEYSWITCH_HIGH: cfg.keyswitch_high = pwdata[6:0];
					REG_LEGATO_GAP:     cfg.legato_gap = pwdata[15:0];
					default: ;
				endcase
			end
			if (evt.valid && evt.ready) begin
				results_q.push_back(filter_note_event(evt.opcode, evt.note, evt.velocity,
					evt.channel, evt.timestamp, evt.voice_active));
			end
			if (res.valid && res.ready) begin
				got.action = act_t'(res.action);
				got.note = res.out_note;
				got.velocity = res.out_velocity;
				got.channel = res.out_channel;
				got.glide = res.glide_ms;
				got.style = res.style_index;
				if (results_q.size() == 0) begin
					if (fail_count < 10) begin
						$display("%0t: result item with none outstanding: act %0d note %0d",
							$time, res.action, res.out_note);
					end
					fail_count++;
				end else begin
					want = results_q.pop_front();
					if (got !== want) begin
						if (fail_count < 10) begin
							$display({"%0t: result mismatch: expected act %0d note %0d vel %0d ",
								"ch %0d glide %0d style %0d, got act %0d note %0d vel %0d ",
								"ch %0d glide %0d style %0d"}, $time,
								want.action, want.note, want.velocity, want.channel,
								want.glide, want.style, got.action, got.note,
								got.velocity, got.channel, got.glide, got.style);
						end
						fail_count++;
					end
				end
			end
			results_due <= results_q.size();
		end
	end

endmodule

// ----- verif/tb_mono_legato_note_filter_unit.sv -----
`timescale 1ns / 100ps
// Testbench top for the mono legato note filter: drives note events and
// register writes, stalls the result channel and gives the verdict.
// Depends on mlnf_pkg, mlnf_if, the filter RTL and mlnf_checker.
module tb_mono_legato_note_filter_unit;
	import mlnf_pkg::*;

	localparam int HELD_DEPTH    = 16;
	localparam int SETTLE_CYCLES = HELD_DEPTH + 14;

	localparam logic [1:0] OP_OTHER = 2'd2;
	localparam logic [1:0] OP_SPARE = 2'd3;

	// Idle patterns for either side of the block.
	localparam int IDLE_NONE   = 0;
	localparam int IDLE_FULL   = 1;
	localparam int IDLE_SPARSE = 2;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	int unsigned fail_count;
	int unsigned results_due;

	int          src_mode;
	int          sink_mode;
	int unsigned items_sent;
	int unsigned stall_left;
	logic [47:0] now;
	int          cur_lo;
	int          cur_hi;
	int unsigned cur_gap;

	mlnf_evt_if note_evt();
	mlnf_res_if note_res();

	mono_legato_note_filter_unit #(.HELD_DEPTH(HELD_DEPTH)) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.note_evt (note_evt),
		.note_res (note_res),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	mlnf_checker #(.HELD_DEPTH(HELD_DEPTH)) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.evt         (note_evt),
		.res         (note_res),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.fail_count  (fail_count),
		.results_due (results_due)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	initial begin
		#(20_000_000);
		$display("== FAIL ==");
		$finish;
	end

	function automatic int unsigned draw_wait(int mode);
		case (mode)
			IDLE_NONE: return 0;
			IDLE_FULL: return $urandom_range(0, 18);
			default:   return ($urandom_range(0, 4) == 0) ? $urandom_range(1, 18) : 0;
		endcase
	endfunction

	// Result side: after each accepted item, hold ready low for a drawn stall, which may be none.
	initial begin
		note_res.ready = 1'b0;
		stall_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (stall_left != 0) begin
				stall_left--;
				if (stall_left == 0) begin
					note_res.ready <= 1'b1;
				end
			end else if (note_res.ready && note_res.valid) begin
				stall_left = draw_wait(sink_mode);
				if (stall_left != 0) begin
					note_res.ready <= 1'b0;
				end
			end else begin
				note_res.ready <= 1'b1;
			end
		end
	end

	// Offers one event; valid stays high when the next item follows at once.
	task automatic send_event(logic [1:0] op, logic [6:0] n, logic [6:0] vel,
			logic [3:0] ch, logic [47:0] ts, logic active);
		int unsigned w;
		w = draw_wait(src_mode);
		if (w != 0) begin
			note_evt.valid <= 1'b0;
			repeat (w) @(posedge clk);
		end
		note_evt.valid <= 1'b1;
		note_evt.opcode <= op;
		note_evt.note <= n;
		note_evt.velocity <= vel;
		note_evt.channel <= ch;
		note_evt.timestamp <= ts;
		note_evt.voice_active <= active;
		do @(posedge clk); while (!note_evt.ready);
		items_sent++;
	endtask

	// Setup phase, then access phase; psel stays high across back-to-back writes.
	task automatic write_reg(logic [2:0] idx, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	task automatic configure(bit en, int lo, int hi, int kl, int kh, int unsigned gap);
		write_reg(REG_LEGATO_ENABLE, 32'(en));
		write_reg(REG_LOWEST_NOTE, 32'(lo));
		write_reg(REG_HIGHEST_NOTE, 32'(hi));
		write_reg(REG_KEYSWITCH_LOW, 32'(kl));
		write_reg(REG_KEYSWITCH_HIGH, 32'(kh));
		write_reg(REG_LEGATO_GAP, 32'(gap));
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		cur_lo = lo;
		cur_hi = hi;
		cur_gap = gap;
	endtask

	// Waits for every outstanding result and lets the block settle.
	task automatic wait_idle();
		note_evt.valid <= 1'b0;
		do @(posedge clk); while (results_due != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Timestamp for a note-on: mostly past the gap, sometimes too soon or backwards.
	function automatic logic [47:0] next_on_ts();
		int r;
		r = $urandom_range(0, 15);
		if (r == 0) begin
			now = now - 48'($urandom_range(1, 5000));
		end else if (r == 1) begin
			now = now + 48'($urandom_range(0, cur_gap));
		end else if (r == 2) begin
			now = now + 48'(cur_gap);
		end else begin
			now = now + 48'(cur_gap) + 48'($urandom_range(1, 2000));
		end
		return now;
	endfunction

	function automatic logic is_voiced();
		return $urandom_range(0, 9) != 0;
	endfunction

	// A played phrase: a run of note-ons near each other, then releases.
	task automatic play_phrase();
		logic [6:0] notes[$];
		int         len, i, pos, lo, hi, cur, d, dir;
		bit         long_run;
		if (cur_lo <= cur_hi) begin
			lo = cur_lo;
			hi = cur_hi;
		end else begin
			lo = 0;
			hi = 127;
		end
		long_run = $urandom_range(0, 6) == 0;
		len = long_run ? $urandom_range(17, 22) : $urandom_range(1, 6);
		dir = $urandom_range(0, 1) ? 1 : -1;
		cur = long_run ? ((dir > 0) ? lo : hi) : $urandom_range(lo, hi);
		for (i = 0; i < len; i++) begin
			if (i > 0) begin
				if (long_run) begin
					d = ($urandom_range(0, 2) != 0) ? 1 : 2;
				end else begin
					case ($urandom_range(0, 9))
						0:       d = 0;
						1:       d = $urandom_range(8, 12);
						default: d = $urandom_range(1, 7);
					endcase
					dir = $urandom_range(0, 1) ? 1 : -1;
				end
				if (cur + dir * d > hi || cur + dir * d < lo) begin
					dir = -dir;
				end
				cur = cur + dir * d;
				if (cur > hi) cur = hi;
				if (cur < lo) cur = lo;
			end
			send_event(OP_NOTE_ON, 7'(cur), 7'($urandom_range(1, 127)),
				4'($urandom_range(0, 15)), next_on_ts(), is_voiced());
			notes.push_back(7'(cur));
		end
		// Release mostly newest first, now and then one from the middle.
		while (notes.size() != 0 && $urandom_range(0, 15) != 0) begin
			pos = ($urandom_range(0, 2) != 0) ? notes.size() - 1
				: $urandom_range(0, notes.size() - 1);
			now = now + 48'($urandom_range(0, 3000));
			if ($urandom_range(0, 4) == 0) begin
				send_event(OP_NOTE_ON, notes[pos], 7'd0, 4'($urandom_range(0, 15)), now,
					is_voiced());
			end else begin
				send_event(OP_NOTE_OFF, notes[pos], 7'($urandom_range(0, 127)),
					4'($urandom_range(0, 15)), now, is_voiced());
			end
			notes.delete(pos);
		end
	endtask

	// Any event at all, with a timestamp anywhere in its range.
	task automatic send_noise();
		logic [47:0] ts;
		ts[47:32] = 16'($urandom_range(0, 16'hFFFF));
		ts[31:0] = $urandom;
		if ($urandom_range(0, 1) == 0) begin
			ts = now;
		end else if ($urandom_range(0, 3) == 0) begin
			now = ts;
		end
		send_event(2'($urandom_range(0, 3)), 7'($urandom_range(0, 127)),
			7'($urandom_range(0, 127)), 4'($urandom_range(0, 15)), ts,
			1'($urandom_range(0, 1)));
	endtask

	task automatic run_random(int unsigned count);
		int unsigned goal;
		goal = items_sent + count;
		while (items_sent < goal) begin
			if ($urandom_range(0, 5) == 0) begin
				src_mode = $urandom_range(IDLE_NONE, IDLE_SPARSE);
				sink_mode = $urandom_range(IDLE_NONE, IDLE_SPARSE);
			end
			if ($urandom_range(0, 9) < 7) begin
				play_phrase();
			end else begin
				send_noise();
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		note_evt.valid = 1'b0;
		note_evt.opcode = OP_NOTE_ON;
		note_evt.note = '0;
		note_evt.velocity = '0;
		note_evt.channel = '0;
		note_evt.timestamp = '0;
		note_evt.voice_active = 1'b0;
		src_mode = IDLE_FULL;
		sink_mode = IDLE_FULL;
		items_sent = 0;
		now = '0;
		cur_lo = int'(RST_LOWEST_NOTE);
		cur_hi = int'(RST_HIGHEST_NOTE);
		cur_gap = int'(RST_LEGATO_GAP);
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed events under the reset settings.
		send_event(OP_OTHER, 7'd127, 7'd127, 4'd15, 48'hFFFF_FFFF_FFFF, 1'b1);
		send_event(OP_SPARE, 7'd0, 7'd0, 4'd0, 48'd0, 1'b0);
		send_event(OP_NOTE_ON, 7'd24, 7'd100, 4'd3, 48'd10, 1'b1);
		send_event(OP_NOTE_ON, 7'd27, 7'd1, 4'd4, 48'd20, 1'b1);
		send_event(OP_NOTE_OFF, 7'd25, 7'd64, 4'd5, 48'd30, 1'b1);
		send_event(OP_NOTE_ON, 7'd10, 7'd64, 4'd6, 48'd40, 1'b1);
		send_event(OP_NOTE_ON, 7'd100, 7'd64, 4'd7, 48'd50, 1'b1);
		// First note-on with nothing sounding, then legato steps of two, three and seven.
		send_event(OP_NOTE_ON, 7'd40, 7'd90, 4'd1, 48'd1000, 1'b1);
		send_event(OP_NOTE_ON, 7'd42, 7'd91, 4'd1, 48'd4000, 1'b1);
		send_event(OP_NOTE_ON, 7'd45, 7'd92, 4'd1, 48'd7000, 1'b1);
		send_event(OP_NOTE_ON, 7'd52, 7'd93, 4'd1, 48'd10000, 1'b1);
		// Step too large, too soon, no voice, then legato again.
		send_event(OP_NOTE_ON, 7'd60, 7'd94, 4'd2, 48'd13000, 1'b1);
		send_event(OP_NOTE_ON, 7'd61, 7'd95, 4'd2, 48'd13100, 1'b1);
		send_event(OP_NOTE_ON, 7'd62, 7'd96, 4'd2, 48'd16200, 1'b0);
		send_event(OP_NOTE_ON, 7'd63, 7'd97, 4'd2, 48'd19000, 1'b1);
		// Exactly the gap apart, then time running backwards.
		send_event(OP_NOTE_ON, 7'd64, 7'd98, 4'd2, 48'd21646, 1'b1);
		send_event(OP_NOTE_ON, 7'd65, 7'd99, 4'd2, 48'd5, 1'b1);
		send_event(OP_NOTE_ON, 7'd66, 7'd100, 4'd2, 48'd3000, 1'b1);
		// Pull-off with a voice, and without one.
		send_event(OP_NOTE_OFF, 7'd66, 7'd20, 4'd8, 48'd3100, 1'b1);
		send_event(OP_NOTE_ON, 7'd66, 7'd101, 4'd8, 48'd6000, 1'b1);
		send_event(OP_NOTE_OFF, 7'd66, 7'd21, 4'd8, 48'd6100, 1'b0);
		send_event(OP_NOTE_OFF, 7'd65, 7'd22, 4'd8, 48'd6200, 1'b1);
		// A zero-velocity note-on as the last release, then a release with nothing sounding.
		send_event(OP_NOTE_ON, 7'd66, 7'd0, 4'd8, 48'd6300, 1'b1);
		send_event(OP_NOTE_OFF, 7'd50, 7'd23, 4'd9, 48'd6400, 1'b1);
		now = 48'd6400;

		run_random(230);
		wait_idle();
		configure(1'b0, 0, 127, 0, 0, 0);
		run_random(250);
		wait_idle();
		configure(1'b1, 0, 127, 127, 0, 0);
		run_random(250);
		wait_idle();
		configure(1'b1, 100, 20, 127, 127, 65535);
		run_random(150);
		wait_idle();
		configure(1'b1, 36, 90, 120, 127, 65535);
		run_random(250);
		wait_idle();
		begin
			int lo, kl;
			lo = $urandom_range(0, 40);
			kl = $urandom_range(0, 120);
			configure($urandom_range(0, 3) != 0, lo, $urandom_range(lo + 10, 127), kl,
				kl + $urandom_range(0, 7), $urandom_range(0, 8000));
		end
		run_random(250);
		wait_idle();
		configure(RST_LEGATO_ENABLE, int'(RST_LOWEST_NOTE), int'(RST_HIGHEST_NOTE),
			int'(RST_KEYSWITCH_LOW), int'(RST_KEYSWITCH_HIGH), int'(RST_LEGATO_GAP));
		run_random(200);
		wait_idle();

		if (fail_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
